/* hw/rtl/vpi_pkg.sv */
// vpi_pkg: shared widths, codes, reset values, config struct and saturation helper
// for the Verlet particle integrator. No dependencies.
package vpi_pkg;

    localparam int PART_W     = 10;
    localparam int DATA_W     = 32;
    localparam int MASS_W     = 31;
    localparam int QF         = 16;            // fraction bits of Q16.16
    localparam int QB         = 32;            // quotient bits per divide
    localparam int DIV_LAT    = QB + 2;        // prep + one bit per stage + sign/sat
    localparam int AX_LAT     = 2 * DIV_LAT + 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AIR_FRICTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING      = 2'd2;

    localparam logic [30:0] RST_TIME_STEP    = 31'd2163;
    localparam logic [30:0] RST_AIR_FRICTION = 31'd6554;
    localparam logic [16:0] RST_DAMPING      = 17'd64225;

    typedef struct packed {
        logic [30:0] time_step;
        logic [30:0] air_friction;
        logic [16:0] damping;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) res = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648) res = 32'sh8000_0000;
        else res = v[31:0];
        return res;
    endfunction

endpackage

/* hw/rtl/verlet_particle_integrator.sv */
// verlet_particle_integrator: top level, particle stores, hazard check, control
// delay line. Uses vpi_pkg and three vpi_axis lanes (each with two vpi_qdiv).
//
// Usage: a beat is taken at a rising edge with start high and busy low. Every
// beat, load or step, gives exactly one result beat after the pipeline's stages,
// shown on the o_ ports with o_valid high for a single cycle; the receiver
// cannot hold it off, so it must take every result beat as it comes. Beats on
// distinct particles go in one per cycle. busy rises while the offered
// particle (index taken modulo NUM_PARTICLES) still has a beat in the pipeline,
// since the step needs the stored position that the earlier beat writes back
// in its result cycle; such a beat waits until that write-back. The latency is set
// by the two 32-stage restoring dividers per axis (velocity by dt, then
// acceleration by mass) plus the multiply and saturate stages around them.
// Stores are not cleared at reset: stepping a particle never loaded gives
// undefined positions. Configuration writes take effect at once and should
// only be issued while no beat is in flight.
module verlet_particle_integrator #(
    parameter int NUM_PARTICLES = 1024,
    parameter int COORD_BITS    = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_we,
    input  logic [vpi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vpi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_op,
    input  logic [vpi_pkg::PART_W-1:0]     i_particle,
    input  logic signed [31:0]             i_a_x,
    input  logic signed [31:0]             i_a_y,
    input  logic signed [31:0]             i_a_z,
    input  logic signed [31:0]             i_ext_x,
    input  logic signed [31:0]             i_ext_y,
    input  logic signed [31:0]             i_ext_z,
    input  logic [vpi_pkg::MASS_W-1:0]     i_mass,
    output logic                           o_valid,
    output logic [vpi_pkg::PART_W-1:0]     o_index_out,
    output logic signed [31:0]             o_pos_x,
    output logic signed [31:0]             o_pos_y,
    output logic signed [31:0]             o_pos_z
);
    localparam int CB     = COORD_BITS;
    localparam int PW     = vpi_pkg::PART_W;
    localparam int IDX_W  = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
    localparam int AX_LAT = vpi_pkg::AX_LAT;
    localparam int LAST   = AX_LAT - 1;
    localparam int TOT    = AX_LAT + 2;

    // particle index modulo the store depth, one compare-subtract per bit
    function automatic logic [IDX_W-1:0] f_wrap(input logic [PW-1:0] p);
        logic [31:0] x;
        logic [31:0] lim;
        x = 32'(p);
        for (int k = PW - 1; k >= 0; k--) begin
            lim = 32'(NUM_PARTICLES) << k;
            if (x >= lim) x = x - lim;
        end
        return IDX_W'(x);
    endfunction

    // load position clipped to the coordinate width
    function automatic logic signed [CB-1:0] f_sat_pos(input logic signed [31:0] a);
        logic signed [63:0] v;
        logic signed [63:0] hi;
        v  = 64'(a);
        hi = (64'sd1 <<< (CB - 1)) - 64'sd1;
        if (v > hi) v = hi;
        else if (v < -hi - 64'sd1) v = -hi - 64'sd1;
        return CB'(v);
    endfunction

    vpi_pkg::t_cfg r_cfg;

    logic [IDX_W-1:0] in_idx;
    logic             accept;
    logic [AX_LAT+1:0] hit;

    // entry stage
    logic               r_s0_vld;
    logic               r_s0_op;
    logic [IDX_W-1:0]   r_s0_idx;
    logic [PW-1:0]      r_s0_part;
    logic signed [31:0] r_s0_a   [3];
    logic signed [31:0] r_s0_ext [3];

    // store read stage
    logic               r_s1_vld;
    logic               r_s1_op;
    logic [IDX_W-1:0]   r_s1_idx;
    logic [PW-1:0]      r_s1_part;
    logic signed [31:0] r_s1_a   [3];
    logic signed [31:0] r_s1_ext [3];
    logic [6*CB-1:0]    r_rd_pos;
    logic [30:0]        r_rd_mass;

    // stores: {cur_x, cur_y, cur_z, old_x, old_y, old_z} and mass
    logic [6*CB-1:0]    pos_mem  [NUM_PARTICLES];
    logic [30:0]        mass_mem [NUM_PARTICLES];

    logic signed [CB-1:0] rd_cur [3];
    logic signed [CB-1:0] rd_old [3];
    logic signed [CB-1:0] s1_keep [3];

    // control delay line alongside the axis lanes
    logic                 r_d_vld  [AX_LAT];
    logic                 r_d_op   [AX_LAT];
    logic [IDX_W-1:0]     r_d_idx  [AX_LAT];
    logic [PW-1:0]        r_d_part [AX_LAT];
    logic signed [CB-1:0] r_d_keep [AX_LAT][3];

    logic                 ax_vld [3];
    logic signed [CB-1:0] ax_new [3];
    logic signed [CB-1:0] fin_pos [3];
    logic [6*CB-1:0]      wb_word;

    assign in_idx = f_wrap(i_particle);

    // hazard: offered particle already somewhere in the pipeline
    always_comb begin
        hit[0] = r_s0_vld && (r_s0_idx == in_idx);
        hit[1] = r_s1_vld && (r_s1_idx == in_idx);
        for (int k = 0; k < AX_LAT; k++)
            hit[k+2] = r_d_vld[k] && (r_d_idx[k] == in_idx);
    end

    assign busy   = |hit;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step    <= vpi_pkg::RST_TIME_STEP;
            r_cfg.air_friction <= vpi_pkg::RST_AIR_FRICTION;
            r_cfg.damping      <= vpi_pkg::RST_DAMPING;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vpi_pkg::CFG_TIME_STEP:    r_cfg.time_step    <= i_cfg_data;
                vpi_pkg::CFG_AIR_FRICTION: r_cfg.air_friction <= i_cfg_data;
                vpi_pkg::CFG_DAMPING:      r_cfg.damping      <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            for (int k = 0; k < AX_LAT; k++) r_d_vld[k] <= 1'b0;
        end else begin
            r_s0_vld   <= accept;
            r_s1_vld   <= r_s0_vld;
            r_d_vld[0] <= r_s1_vld;
            for (int k = 1; k < AX_LAT; k++) r_d_vld[k] <= r_d_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_op     <= i_op;
        r_s0_idx    <= in_idx;
        r_s0_part   <= i_particle;
        r_s0_a[0]   <= i_a_x;
        r_s0_a[1]   <= i_a_y;
        r_s0_a[2]   <= i_a_z;
        r_s0_ext[0] <= i_ext_x;
        r_s0_ext[1] <= i_ext_y;
        r_s0_ext[2] <= i_ext_z;

        r_s1_op   <= r_s0_op;
        r_s1_idx  <= r_s0_idx;
        r_s1_part <= r_s0_part;
        r_s1_a    <= r_s0_a;
        r_s1_ext  <= r_s0_ext;

        r_d_op[0]   <= r_s1_op;
        r_d_idx[0]  <= r_s1_idx;
        r_d_part[0] <= r_s1_part;
        r_d_keep[0] <= s1_keep;
        for (int k = 1; k < AX_LAT; k++) begin
            r_d_op[k]   <= r_d_op[k-1];
            r_d_idx[k]  <= r_d_idx[k-1];
            r_d_part[k] <= r_d_part[k-1];
            r_d_keep[k] <= r_d_keep[k-1];
        end
    end

    // mass has one writer, so a load puts it away on acceptance
    always_ff @(posedge i_clk) begin
        if (accept && (i_op == vpi_pkg::OP_LOAD)) mass_mem[in_idx] <= i_mass;
        r_rd_mass <= mass_mem[r_s0_idx];
    end

    // positions written back in the result cycle
    always_ff @(posedge i_clk) begin
        if (r_d_vld[LAST]) pos_mem[r_d_idx[LAST]] <= wb_word;
        r_rd_pos <= pos_mem[r_s0_idx];
    end

    // keep: loaded position on a load, the old current position on a step;
    // it becomes the previous position at write-back
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rd_cur[i]  = r_rd_pos[(5 - i) * CB +: CB];
            rd_old[i]  = r_rd_pos[(2 - i) * CB +: CB];
            s1_keep[i] = (r_s1_op == vpi_pkg::OP_STEP) ? rd_cur[i] : f_sat_pos(r_s1_a[i]);
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_axis
        vpi_axis #(.COORD_BITS(CB)) u_axis (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_vld   (r_s1_vld),
            .i_cur   (rd_cur[g]),
            .i_old   (rd_old[g]),
            .i_f     (r_s1_a[g]),
            .i_ext   (r_s1_ext[g]),
            .i_mass  (r_rd_mass),
            .o_vld   (ax_vld[g]),
            .o_new   (ax_new[g])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fin_pos[i] = (r_d_op[LAST] == vpi_pkg::OP_LOAD) ? r_d_keep[LAST][i] : ax_new[i];
            wb_word[(5 - i) * CB +: CB] = fin_pos[i];
            wb_word[(2 - i) * CB +: CB] = r_d_keep[LAST][i];
        end
    end

    assign o_valid     = r_d_vld[LAST];
    assign o_index_out = r_d_part[LAST];
    assign o_pos_x     = 32'(fin_pos[0]);
    assign o_pos_y     = 32'(fin_pos[1]);
    assign o_pos_z     = 32'(fin_pos[2]);

    // every accepted beat gives its result beat after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##TOT o_valid)
        else $error("result beat missing after fixed latency");

    // no beat accepted on a particle whose beat is in its result cycle
    a_no_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_d_vld[LAST]) |-> (in_idx != r_d_idx[LAST]))
        else $error("beat accepted on particle still in flight");

    // delay line and axis lanes stay in step
    a_lane_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_vld[LAST] == ax_vld[0]) && (ax_vld[1] == ax_vld[2]))
        else $error("control line and axis lanes out of step");

endmodule

/* hw/rtl/vpi_qdiv.sv */
// vpi_qdiv: pipelined x * 2^16 / d, truncated toward zero, saturated to 32 bits.
// One quotient bit per stage, sideband carried alongside. Uses vpi_pkg.
module vpi_qdiv #(
    parameter int X_W  = 33,
    parameter int SB_W = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  logic signed [X_W-1:0]  i_x,
    input  logic [30:0]            i_d,
    input  logic [SB_W-1:0]        i_sb,
    output logic                   o_vld,
    output logic signed [31:0]     o_q,
    output logic [SB_W-1:0]        o_sb
);
    localparam int QB    = vpi_pkg::QB;
    localparam int CMP_W = (X_W > 31) ? X_W : 31;

    logic [X_W-1:0]   mag;
    logic [CMP_W-1:0] hi;

    logic            r_vld  [0:QB];
    logic [30:0]     r_rem  [0:QB];
    logic [QB-1:0]   r_num  [0:QB];
    logic [QB-1:0]   r_q    [0:QB];
    logic [30:0]     r_d    [0:QB];
    logic            r_neg  [0:QB];
    logic            r_ovf  [0:QB];
    logic            r_zero [0:QB];
    logic [SB_W-1:0] r_sb   [0:QB];

    logic [31:0]     n_rs  [1:QB];
    logic            n_ge  [1:QB];
    logic [30:0]     n_rem [1:QB];
    logic [QB-1:0]   n_num [1:QB];
    logic [QB-1:0]   n_q   [1:QB];

    logic                r_o_vld;
    logic signed [31:0]  r_o_q;
    logic [SB_W-1:0]     r_o_sb;
    logic signed [31:0]  n_o_q;

    // high part of the dividend is the starting remainder; overflow if it reaches d
    always_comb begin
        mag = i_x[X_W-1] ? X_W'(-i_x) : X_W'(i_x);
        hi  = CMP_W'(mag >> vpi_pkg::QF);
    end

    always_comb begin
        for (int k = 1; k <= QB; k++) begin
            n_rs[k]  = {r_rem[k-1], r_num[k-1][QB-1]};
            n_ge[k]  = n_rs[k] >= {1'b0, r_d[k-1]};
            n_rem[k] = n_ge[k] ? 31'(n_rs[k] - {1'b0, r_d[k-1]}) : n_rs[k][30:0];
            n_num[k] = {r_num[k-1][QB-2:0], 1'b0};
            n_q[k]   = {r_q[k-1][QB-2:0], n_ge[k]};
        end
    end

    always_comb begin
        if (r_zero[QB]) begin
            n_o_q = '0;
        end else if (!r_neg[QB]) begin
            n_o_q = (r_ovf[QB] || r_q[QB][31]) ? 32'sh7FFF_FFFF : $signed(r_q[QB]);
        end else begin
            if (r_ovf[QB] || (r_q[QB][31] && (r_q[QB][30:0] != '0)))
                n_o_q = 32'sh8000_0000;
            else
                n_o_q = $signed(-r_q[QB]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) r_vld[k] <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 1; k <= QB; k++) r_vld[k] <= r_vld[k-1];
            r_o_vld <= r_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= hi[30:0];
        r_num[0]  <= {mag[15:0], 16'b0};
        r_q[0]    <= '0;
        r_d[0]    <= i_d;
        r_neg[0]  <= i_x[X_W-1];
        r_ovf[0]  <= hi >= CMP_W'(i_d);
        r_zero[0] <= (i_x == '0);
        r_sb[0]   <= i_sb;
        for (int k = 1; k <= QB; k++) begin
            r_rem[k]  <= n_rem[k];
            r_num[k]  <= n_num[k];
            r_q[k]    <= n_q[k];
            r_d[k]    <= r_d[k-1];
            r_neg[k]  <= r_neg[k-1];
            r_ovf[k]  <= r_ovf[k-1];
            r_zero[k] <= r_zero[k-1];
            r_sb[k]   <= r_sb[k-1];
        end
        r_o_q  <= n_o_q;
        r_o_sb <= r_sb[QB];
    end

    assign o_vld = r_o_vld;
    assign o_q   = r_o_q;
    assign o_sb  = r_o_sb;

endmodule

/* hw/rtl/vpi_axis.sv */
// vpi_axis: one axis of the damped Verlet update as a fixed-latency pipeline.
// Uses vpi_pkg and two vpi_qdiv instances (velocity and acceleration).
module vpi_axis #(
    parameter int COORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vpi_pkg::t_cfg                 i_cfg,
    input  logic                          i_vld,
    input  logic signed [COORD_BITS-1:0]  i_cur,
    input  logic signed [COORD_BITS-1:0]  i_old,
    input  logic signed [31:0]            i_f,
    input  logic signed [31:0]            i_ext,
    input  logic [30:0]                   i_mass,
    output logic                          o_vld,
    output logic signed [COORD_BITS-1:0]  o_new
);
    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 1;
    localparam int CW    = DW + 2;
    localparam int SUM_W = ((CW > 32) ? CW : 32) + 2;
    localparam int SB1_W = CB + 32 + 32 + 31 + DW;
    localparam int SB2_W = CB + CW;
    localparam logic signed [SUM_W-1:0] CMAX = SUM_W'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] CMIN = -CMAX - SUM_W'(1);

    // entry
    logic                 r_p1_vld;
    logic signed [DW-1:0] r_p1_disp;
    logic signed [CB-1:0] r_p1_cur;
    logic signed [31:0]   r_p1_f, r_p1_ext;
    logic [30:0]          r_p1_mass;

    // velocity divide
    logic                 d1_vld;
    logic signed [31:0]   d1_vel;
    logic [SB1_W-1:0]     d1_sb;
    logic signed [CB-1:0] d1_cur;
    logic signed [31:0]   d1_f, d1_ext;
    logic [30:0]          d1_mass;
    logic signed [DW-1:0] d1_disp;

    logic                     r_m1_vld;
    logic signed [63:0]       r_m1_dragp;
    logic signed [DW+17:0]    r_m1_carryp;
    logic signed [CB-1:0]     r_m1_cur;
    logic signed [31:0]       r_m1_f, r_m1_ext;
    logic [30:0]              r_m1_mass;

    logic signed [31:0]   drag;
    logic                 r_m2_vld;
    logic signed [31:0]   r_m2_force;
    logic signed [CW-1:0] r_m2_carry;
    logic signed [CB-1:0] r_m2_cur;
    logic [30:0]          r_m2_mass;

    // acceleration divide
    logic                 d2_vld;
    logic signed [31:0]   d2_acc;
    logic [SB2_W-1:0]     d2_sb;

    logic                 r_m3_vld, r_m4_vld, r_m5_vld, r_m6_vld, r_m7_vld;
    logic signed [63:0]   r_m3_t1p, r_m5_t2p;
    logic signed [31:0]   r_m4_t1, r_m6_t2;
    logic [SB2_W-1:0]     r_m3_sb, r_m4_sb, r_m5_sb, r_m6_sb;
    logic signed [CB-1:0] m6_cur;
    logic signed [CW-1:0] m6_carry;
    logic signed [SUM_W-1:0] sum;
    logic signed [CB-1:0] r_m7_new;

    always_ff @(posedge i_clk) begin
        r_p1_disp <= DW'(i_cur) - DW'(i_old);
        r_p1_cur  <= i_cur;
        r_p1_f    <= i_f;
        r_p1_ext  <= i_ext;
        r_p1_mass <= i_mass;
    end

    vpi_qdiv #(.X_W(DW), .SB_W(SB1_W)) u_div_vel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p1_vld),
        .i_x     (r_p1_disp),
        .i_d     (i_cfg.time_step),
        .i_sb    ({r_p1_cur, r_p1_f, r_p1_ext, r_p1_mass, r_p1_disp}),
        .o_vld   (d1_vld),
        .o_q     (d1_vel),
        .o_sb    (d1_sb)
    );

    assign {d1_cur, d1_f, d1_ext, d1_mass, d1_disp} = d1_sb;

    // drag and displacement carry products
    always_ff @(posedge i_clk) begin
        r_m1_dragp  <= d1_vel * $signed({1'b0, i_cfg.air_friction});
        r_m1_carryp <= d1_disp * $signed({1'b0, i_cfg.damping});
        r_m1_cur    <= d1_cur;
        r_m1_f      <= d1_f;
        r_m1_ext    <= d1_ext;
        r_m1_mass   <= d1_mass;
    end

    assign drag = vpi_pkg::sat32(64'(r_m1_dragp >>> vpi_pkg::QF));

    always_ff @(posedge i_clk) begin
        r_m2_force <= vpi_pkg::sat32(64'(r_m1_f) + 64'(r_m1_ext) - 64'(drag));
        r_m2_carry <= CW'(r_m1_carryp >>> vpi_pkg::QF);
        r_m2_cur   <= r_m1_cur;
        r_m2_mass  <= r_m1_mass;
    end

    vpi_qdiv #(.X_W(32), .SB_W(SB2_W)) u_div_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_m2_vld),
        .i_x     (r_m2_force),
        .i_d     (r_m2_mass),
        .i_sb    ({r_m2_cur, r_m2_carry}),
        .o_vld   (d2_vld),
        .o_q     (d2_acc),
        .o_sb    (d2_sb)
    );

    // acc * dt * dt, each product floored back to Q16.16 and saturated
    always_ff @(posedge i_clk) begin
        r_m3_t1p <= d2_acc * $signed({1'b0, i_cfg.time_step});
        r_m3_sb  <= d2_sb;
        r_m4_t1  <= vpi_pkg::sat32(64'(r_m3_t1p >>> vpi_pkg::QF));
        r_m4_sb  <= r_m3_sb;
        r_m5_t2p <= r_m4_t1 * $signed({1'b0, i_cfg.time_step});
        r_m5_sb  <= r_m4_sb;
        r_m6_t2  <= vpi_pkg::sat32(64'(r_m5_t2p >>> vpi_pkg::QF));
        r_m6_sb  <= r_m5_sb;
        r_m7_new <= (sum > CMAX) ? CB'(CMAX) : ((sum < CMIN) ? CB'(CMIN) : CB'(sum));
    end

    assign {m6_cur, m6_carry} = r_m6_sb;
    assign sum = SUM_W'(m6_cur) + SUM_W'(m6_carry) + SUM_W'(r_m6_t2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
            r_m4_vld <= 1'b0;
            r_m5_vld <= 1'b0;
            r_m6_vld <= 1'b0;
            r_m7_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_vld;
            r_m1_vld <= d1_vld;
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= d2_vld;
            r_m4_vld <= r_m3_vld;
            r_m5_vld <= r_m4_vld;
            r_m6_vld <= r_m5_vld;
            r_m7_vld <= r_m6_vld;
        end
    end

    assign o_vld = r_m7_vld;
    assign o_new = r_m7_new;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for verlet_particle_integrator: drives load and step beats,
// predicts each position result with a Q16.16 integrator model and checks it.
// Depends on vpi_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;

    localparam int NPART     = 1024;
    localparam int LIMIT     = 400000;   // cycles
    localparam int DRAIN_CYC = 100;      // pipeline is 78 deep

    typedef struct {
        logic              op;
        logic [9:0]        particle;
        logic signed [31:0] a [3];
        logic signed [31:0] ext [3];
        logic [30:0]       mass;
    } t_beat;

    typedef struct {
        logic [9:0]         index;
        logic signed [31:0] pos [3];
    } t_pos;

    // Scoreboard: own copy of particle stores and registers, queue of expected positions
    class particle_scoreboard;
        longint cur [NPART][3];
        longint prev [NPART][3];
        longint mass_mem [NPART];
        longint dt, drag_k, damp;
        t_pos   pending [$];
        int     errors;

        function new();
            dt = vpi_pkg::RST_TIME_STEP;
            drag_k = vpi_pkg::RST_AIR_FRICTION;
            damp = vpi_pkg::RST_DAMPING;
            errors = 0;
        endfunction

        function void write_reg(logic [vpi_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
            case (idx)
                vpi_pkg::CFG_TIME_STEP:    dt = val;
                vpi_pkg::CFG_AIR_FRICTION: drag_k = val;
                vpi_pkg::CFG_DAMPING:      damp = val[16:0];
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // x * 2^16 / d, truncated toward zero, clipped
        function longint qdiv(longint x, longint d);
            longint q, r;
            if (d == 0) return (x > 0) ? 64'sd2147483647 : (x < 0) ? -64'sd2147483648 : 0;
            q = x / d;
            r = x % d;
            if (q > 64'sd2147483647 || q < -64'sd2147483648)
                return (q > 0) ? 64'sd2147483647 : -64'sd2147483648;
            return clip32(q * 65536 + (r * 65536) / d);
        endfunction

        function longint integrate(longint c, longint o, longint f, longint e, longint m);
            longint disp, vel, drag, frc, acc, t1, t2, hi, lo, carry;
            disp  = c - o;
            vel   = qdiv(disp, dt);
            drag  = clip32((vel * drag_k) >>> 16);
            frc   = clip32(f + e - drag);
            acc   = qdiv(frc, m);
            t1    = clip32((acc * dt) >>> 16);
            t2    = clip32((t1 * dt) >>> 16);
            hi    = disp >>> 16;
            lo    = disp - hi * 65536;
            carry = hi * damp + ((lo * damp) >>> 16);
            return clip32(c + carry + t2);
        endfunction

        function void note(t_beat b);
            t_pos   r;
            int     i;
            longint nv [3];
            i = b.particle % NPART;
            r.index = b.particle;
            for (int k = 0; k < 3; k++) begin
                if (b.op == vpi_pkg::OP_LOAD) begin
                    nv[k] = b.a[k];
                    prev[i][k] = nv[k];
                end else begin
                    nv[k] = integrate(cur[i][k], prev[i][k], b.a[k], b.ext[k], mass_mem[i]);
                    prev[i][k] = cur[i][k];
                end
                cur[i][k] = nv[k];
                r.pos[k] = nv[k][31:0];
            end
            if (b.op == vpi_pkg::OP_LOAD) mass_mem[i] = b.mass;
            pending.push_back(r);
        endfunction

        function void check(t_pos got);
            t_pos exp_p;
            if (pending.size() == 0) begin
                $error("unexpected result beat for particle %0d", got.index);
                errors++;
                return;
            end
            exp_p = pending.pop_front();
            if (got.index !== exp_p.index) begin
                $error("index_out: expected %0d, got %0d", exp_p.index, got.index);
                errors++;
            end
            if (got.pos[0] !== exp_p.pos[0]) begin
                $error("pos_x: expected %0d, got %0d", exp_p.pos[0], got.pos[0]);
                errors++;
            end
            if (got.pos[1] !== exp_p.pos[1]) begin
                $error("pos_y: expected %0d, got %0d", exp_p.pos[1], got.pos[1]);
                errors++;
            end
            if (got.pos[2] !== exp_p.pos[2]) begin
                $error("pos_z: expected %0d, got %0d", exp_p.pos[2], got.pos[2]);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic                           i_cfg_we = 1'b0;
    logic [vpi_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [vpi_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_op = vpi_pkg::OP_LOAD;
    logic [vpi_pkg::PART_W-1:0]     i_particle = '0;
    logic signed [31:0]             i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [31:0]             i_ext_x = '0, i_ext_y = '0, i_ext_z = '0;
    logic [vpi_pkg::MASS_W-1:0]     i_mass = '0;
    logic                           o_valid;
    logic [vpi_pkg::PART_W-1:0]     o_index_out;
    logic signed [31:0]             o_pos_x, o_pos_y, o_pos_z;

    particle_scoreboard sb = new();
    bit  loaded [NPART];
    bit  no_gaps;
    int  cycles = 0;

    verlet_particle_integrator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_op(i_op), .i_particle(i_particle),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_ext_x(i_ext_x), .i_ext_y(i_ext_y), .i_ext_z(i_ext_z),
        .i_mass(i_mass), .o_valid(o_valid), .o_index_out(o_index_out),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z)
    );

    always #1 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** verlet_particle_integrator: FAILED **");
            $finish;
        end
    end

    // result beats sampled mid-cycle, away from the clock edge
    always @(negedge i_clk) begin
        t_pos got;
        if (i_rst_n && o_valid) begin
            got.index  = o_index_out;
            got.pos[0] = o_pos_x;
            got.pos[1] = o_pos_y;
            got.pos[2] = o_pos_z;
            sb.check(got);
        end
    end

    // mix of full-range, small and extreme Q16.16 values
    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2:       return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic logic [30:0] rand_mass();
        case ($urandom_range(0, 3))
            0:       return 31'(($urandom & 32'h7FFF_FFFF) | 32'd1);
            1:       return 31'($urandom_range(1, 16));
            default: return 31'($urandom_range(32'h0000_4000, 32'h0010_0000));
        endcase
    endfunction

    task automatic send(t_beat b);
        bit taken;
        start      <= 1'b1;
        i_op       <= b.op;
        i_particle <= b.particle;
        i_a_x <= b.a[0]; i_a_y <= b.a[1]; i_a_z <= b.a[2];
        i_ext_x <= b.ext[0]; i_ext_y <= b.ext[1]; i_ext_z <= b.ext[2];
        i_mass     <= b.mass;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        sb.note(b);
        if (b.op == vpi_pkg::OP_LOAD) loaded[b.particle] = 1'b1;
        if (!no_gaps && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge i_clk);
            else repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic idle_and_drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [vpi_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_regs(logic [30:0] ts, logic [30:0] af, logic [16:0] dmp);
        write_reg(vpi_pkg::CFG_TIME_STEP, ts);
        write_reg(vpi_pkg::CFG_AIR_FRICTION, af);
        write_reg(vpi_pkg::CFG_DAMPING, {14'd0, dmp});
        @(posedge i_clk);
    endtask

    function automatic t_beat make_beat(logic op, logic [9:0] p);
        t_beat b;
        b.op = op;
        b.particle = p;
        for (int k = 0; k < 3; k++) begin
            b.a[k]   = rand_q();
            b.ext[k] = rand_q();
        end
        b.mass = rand_mass();
        return b;
    endfunction

    // random phase: mostly steps on loaded particles, narrow index window for hazards
    task automatic random_phase(int n);
        t_beat b;
        logic [9:0] p;
        for (int j = 0; j < n; j++) begin
            no_gaps = ((j / 40) % 3 == 2);
            p = ($urandom_range(0, 1)) ? 10'($urandom_range(0, 7))
                                       : 10'($urandom_range(0, NPART - 1));
            if (!loaded[p] || $urandom_range(0, 5) == 0) b = make_beat(vpi_pkg::OP_LOAD, p);
            else b = make_beat(vpi_pkg::OP_STEP, p);
            send(b);
        end
    endtask

    initial begin
        t_beat b;
        no_gaps = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of every field at reset settings
        b = make_beat(vpi_pkg::OP_LOAD, 10'd0);
        b.a = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0};
        b.ext = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        b.mass = 31'd1;
        send(b);
        b = make_beat(vpi_pkg::OP_LOAD, 10'd1023);
        b.a = '{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1};
        b.mass = 31'h7FFF_FFFF;
        send(b);
        b = make_beat(vpi_pkg::OP_STEP, 10'd0);          // same particle back to back
        b.a = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0};
        b.ext = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0};
        send(b);
        b.a = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd65536};
        b.ext = '{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd65536};
        send(b);
        b = make_beat(vpi_pkg::OP_STEP, 10'd1023);
        b.a = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
        b.ext = '{32'sh8000_0000, 32'sd0, 32'sh8000_0000};
        send(b);
        send(make_beat(vpi_pkg::OP_STEP, 10'd1023));
        b = make_beat(vpi_pkg::OP_LOAD, 10'h155);
        b.mass = 31'h2AAA_AAAA;
        send(b);
        b = make_beat(vpi_pkg::OP_LOAD, 10'h2AA);
        b.mass = 31'h5555_5555;
        send(b);
        for (int j = 0; j < 6; j++)
            send(make_beat(vpi_pkg::OP_STEP, (j % 2) ? 10'h155 : 10'h2AA));

        // sender holds off until the pipe is empty
        idle_and_drain();

        // settings sweep, extremes first, then random ones
        set_regs(31'd1, 31'd0, 17'd0);
        for (int j = 0; j < 8; j++)
            send(make_beat(vpi_pkg::OP_STEP, j % 2 ? 10'd0 : 10'd1023));
        random_phase(40);
        idle_and_drain();
        set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 17'd65536);
        random_phase(60);
        idle_and_drain();
        set_regs(31'd65536, 31'd65536, 17'd32768);
        random_phase(60);
        idle_and_drain();
        for (int ph = 0; ph < 3; ph++) begin
            set_regs(31'($urandom_range(1, 32'h0002_0000)), 31'($urandom & 32'h7FFF_FFFF),
                     17'($urandom_range(0, 65536)));
            random_phase(60);
            idle_and_drain();
        end
        set_regs(vpi_pkg::RST_TIME_STEP, vpi_pkg::RST_AIR_FRICTION, vpi_pkg::RST_DAMPING);
        random_phase(140);

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("** verlet_particle_integrator: PASSED **");
        end else begin
            $display("** verlet_particle_integrator: FAILED **");
        end
        $finish;
    end

endmodule

/* verlet_particle_integrator.f */
hw/rtl/vpi_pkg.sv
hw/rtl/vpi_qdiv.sv
hw/rtl/vpi_axis.sv
hw/rtl/verlet_particle_integrator.sv
dv/testbench.sv
